// ===== design/aei_pkg.sv =====
// Shared constants and types for the arithmetic-coding interval encoder.
`default_nettype none

package aei_pkg;

  localparam int PRECISION_DEF = 32;
  localparam int FREQ_BITS_DEF = 16;

  // fixed field widths of the request and result channels
  localparam int FieldW  = 16;
  localparam int PendW   = 8;
  localparam int FollowW = 9;

  // rescale iterations allowed per symbol, also the bound on results
  localparam int IterCap = 32;
  localparam int IterW   = $clog2(IterCap + 1);

  typedef enum logic [0:0] {
    CMD_ENCODE = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_SCALE,
    CTL_RESCALE,
    CTL_FINISH
  } ctl_state_e;

  typedef enum logic [1:0] {
    SCL_IDLE,
    SCL_MUL,
    SCL_LOAD,
    SCL_DIV
  } scl_state_e;

endpackage

`default_nettype wire

// ===== design/aei_sym_if.sv =====
// Symbol request channel: command and model frequencies.
`default_nettype none

interface aei_sym_if
  import aei_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              command;
  logic [FieldW-1:0] cum_freq;
  logic [FieldW-1:0] freq;
  logic [FieldW-1:0] total;

  modport source (output valid, output command, output cum_freq, output freq,
                  output total, input ready);
  modport sink   (input valid, input command, input cum_freq, input freq,
                  input total, output ready);
endinterface

`default_nettype wire

// ===== design/aei_res_if.sv =====
// Result channel: emitted lead bit and its follow count.
`default_nettype none

interface aei_res_if
  import aei_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               lead_bit;
  logic [FollowW-1:0] follow_count;
  logic               last;

  modport source (output valid, output lead_bit, output follow_count,
                  output last, input ready);
  modport sink   (input valid, input lead_bit, input follow_count,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== design/aei_scale.sv =====
// Bit-serial round(w*c/t), half up: shift-add multiply then restoring divide.
`default_nettype none

module aei_scale
  import aei_pkg::*;
#(
  parameter int PRECISION = PRECISION_DEF,
  parameter int FREQ_BITS = FREQ_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [PRECISION:0]   w_i,
  input  wire logic [FREQ_BITS-1:0] c_i,
  input  wire logic [FREQ_BITS-1:0] t_i,
  output logic                      done_o,
  output logic [PRECISION:0]        q_o
);

  localparam int AccW   = PRECISION + FREQ_BITS + 1;
  localparam int NumW   = AccW + 1;
  localparam int CntMax = (FREQ_BITS > PRECISION + 1) ? FREQ_BITS : PRECISION + 1;
  localparam int CntW   = $clog2(CntMax + 1);

  scl_state_e state_q, state_d;

  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [AccW-1:0]      acc_q, acc_d;
  logic [PRECISION:0]   w_q, w_d;
  logic [FREQ_BITS-1:0] c_q, c_d;
  logic [FREQ_BITS-1:0] t_q, t_d;
  logic [FREQ_BITS:0]   rem_q, rem_d;
  logic [PRECISION:0]   sh_q, sh_d;
  logic                 done_q, done_d;

  logic                 mul_last, div_last;
  logic [NumW-1:0]      num;
  logic [FREQ_BITS:0]   dsr;
  logic [FREQ_BITS+1:0] trial;
  logic [FREQ_BITS+1:0] diff;
  logic                 ge;

  assign mul_last = (cnt_q == CntW'(FREQ_BITS - 1));
  assign div_last = (cnt_q == CntW'(PRECISION));
  assign num      = {acc_q, 1'b0} + NumW'(t_q);
  assign dsr      = {t_q, 1'b0};
  assign trial    = {rem_q, sh_q[PRECISION]};
  assign diff     = trial - {1'b0, dsr};
  assign ge       = (trial >= {1'b0, dsr});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SCL_IDLE: if (start_i) state_d = SCL_MUL;
      SCL_MUL:  if (mul_last) state_d = SCL_LOAD;
      SCL_LOAD: state_d = SCL_DIV;
      SCL_DIV:  if (div_last) state_d = SCL_IDLE;
      default:  state_d = SCL_IDLE;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    w_d    = w_q;
    c_d    = c_q;
    t_d    = t_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    done_d = 1'b0;
    unique case (state_q)
      SCL_IDLE: begin
        if (start_i) begin
          w_d   = w_i;
          c_d   = c_i;
          t_d   = t_i;
          acc_d = '0;
          cnt_d = '0;
        end
      end
      SCL_MUL: begin
        // MSB first
        acc_d = {acc_q[AccW-2:0], 1'b0} + (c_q[FREQ_BITS-1] ? AccW'(w_q) : '0);
        c_d   = {c_q[FREQ_BITS-2:0], 1'b0};
        cnt_d = cnt_q + CntW'(1);
      end
      SCL_LOAD: begin
        // quotient fits PRECISION+1 bits, so the top part is already below 2t
        rem_d = num[NumW-1:PRECISION+1];
        sh_d  = num[PRECISION:0];
        cnt_d = '0;
      end
      SCL_DIV: begin
        // remainder stays below 2t, so it needs FREQ_BITS+1 bits
        rem_d  = ge ? diff[FREQ_BITS:0] : trial[FREQ_BITS:0];
        sh_d   = {sh_q[PRECISION-1:0], ge};
        cnt_d  = cnt_q + CntW'(1);
        done_d = div_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SCL_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    w_q   <= w_d;
    c_q   <= c_d;
    t_q   <= t_d;
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign q_o    = sh_q;

endmodule

`default_nettype wire

// ===== design/arith_encode_interval_core.sv =====
// Top level: interval narrowing and bit-plus-follow rescaling of the encoder.
//
// Channel | Dir | Handshake     | Payload
// sym_i   | in  | valid / ready | command, cum_freq, freq, total
// res_o   | out | valid / ready | lead_bit, follow_count, last
//
// Symbol request: after accept, the two serial scalers run their multiply, load and
//   divide steps, then the bounds are updated, then rescale iterates (at most 32
//   iterations) and closes.
// Finish request: after accept, the result is loaded once the output register is free.
// Requests are taken one at a time, only in idle; a result may still be waiting.
// Rescale stalls while a bit is held and the output register is still full.
// Reset: interval [0, 2^PRECISION), pending count zero.
`default_nettype none

module arith_encode_interval_core
  import aei_pkg::*;
#(
  parameter int PRECISION = PRECISION_DEF,
  parameter int FREQ_BITS = FREQ_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  aei_sym_if.sink    sym_i,
  aei_res_if.source  res_o
);

  localparam logic [PRECISION:0] Whole    = {1'b1, {PRECISION{1'b0}}};
  localparam logic [PRECISION:0] Half     = Whole >> 1;
  localparam logic [PRECISION:0] Quarter  = Whole >> 2;
  localparam logic [PRECISION:0] TQuarter = Half + Quarter;
  localparam int                 ExtW     = (FREQ_BITS > FieldW) ? FREQ_BITS : FieldW;

  ctl_state_e state_q, state_d;

  logic [PRECISION:0] low_q, low_d;
  logic [PRECISION:0] high_q, high_d;
  logic [PendW-1:0]   pend_q, pend_d;
  logic [IterW-1:0]   iter_q, iter_d;

  // result waiting to learn whether it closes the request
  logic               held_q, held_d;
  logic               held_bit_q, held_bit_d;
  logic [PendW-1:0]   held_cnt_q, held_cnt_d;

  logic               out_valid_q, out_valid_d;
  logic               out_bit_q, out_bit_d;
  logic [FollowW-1:0] out_cnt_q, out_cnt_d;
  logic               out_last_q, out_last_d;

  logic [ExtW-1:0]      cum_x, fr_x, tot_x;
  logic [FREQ_BITS-1:0] cum_m, fr_m, tot_m, tot_c, lo_c, hi_c;
  logic [FREQ_BITS:0]   hi_sum;
  logic [PRECISION:0]   width_v, q_lo, q_hi;
  logic                 done_lo, done_hi;

  logic accept, start, out_free;
  logic cond_lo, cond_hi, cond_mid, at_cap, emit, mid, stop, step_ok;
  logic [PRECISION:0] low_sub, high_sub;

  // field masking and saturation of the model's frequencies
  assign cum_x  = ExtW'(sym_i.cum_freq);
  assign fr_x   = ExtW'(sym_i.freq);
  assign tot_x  = ExtW'(sym_i.total);
  assign cum_m  = cum_x[FREQ_BITS-1:0];
  assign fr_m   = fr_x[FREQ_BITS-1:0];
  assign tot_m  = tot_x[FREQ_BITS-1:0];
  assign tot_c  = (tot_m == '0) ? FREQ_BITS'(1) : tot_m;
  assign hi_sum = {1'b0, cum_m} + {1'b0, fr_m};
  assign hi_c   = (hi_sum > {1'b0, tot_c}) ? tot_c : hi_sum[FREQ_BITS-1:0];
  assign lo_c   = (cum_m > tot_c) ? tot_c : cum_m;
  assign width_v = high_q - low_q;

  assign sym_i.ready = (state_q == CTL_IDLE);
  assign accept      = sym_i.valid && sym_i.ready;
  assign start       = accept && (sym_i.command == CMD_ENCODE);
  assign out_free    = !out_valid_q || res_o.ready;

  aei_scale #(
    .PRECISION (PRECISION),
    .FREQ_BITS (FREQ_BITS)
  ) u_scale_lo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .w_i     (width_v),
    .c_i     (lo_c),
    .t_i     (tot_c),
    .done_o  (done_lo),
    .q_o     (q_lo)
  );

  aei_scale #(
    .PRECISION (PRECISION),
    .FREQ_BITS (FREQ_BITS)
  ) u_scale_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .w_i     (width_v),
    .c_i     (hi_c),
    .t_i     (tot_c),
    .done_o  (done_hi),
    .q_o     (q_hi)
  );

  // rescale decode
  assign cond_lo  = (high_q < Half);
  assign cond_hi  = (low_q > Half);
  assign cond_mid = (low_q > Quarter) && (high_q < TQuarter);
  assign at_cap   = (iter_q == IterW'(IterCap));
  assign emit     = !at_cap && (cond_lo || cond_hi);
  assign mid      = !at_cap && !emit && cond_mid;
  assign stop     = !emit && !mid;
  assign step_ok  = !held_q || out_free;

  always_comb begin
    low_sub  = low_q;
    high_sub = high_q;
    if (emit && !cond_lo) begin
      low_sub  = low_q - Half;
      high_sub = high_q - Half;
    end else if (mid) begin
      low_sub  = low_q - Quarter;
      high_sub = high_q - Quarter;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CTL_IDLE: begin
        if (accept) begin
          state_d = (sym_i.command == CMD_FINISH) ? CTL_FINISH : CTL_SCALE;
        end
      end
      CTL_SCALE:   if (done_lo) state_d = CTL_RESCALE;
      CTL_RESCALE: if (stop && step_ok) state_d = CTL_IDLE;
      CTL_FINISH:  if (out_free) state_d = CTL_IDLE;
      default:     state_d = CTL_IDLE;
    endcase
  end

  always_comb begin
    low_d       = low_q;
    high_d      = high_q;
    pend_d      = pend_q;
    iter_d      = iter_q;
    held_d      = held_q;
    held_bit_d  = held_bit_q;
    held_cnt_d  = held_cnt_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_bit_d   = out_bit_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      CTL_IDLE: ;
      CTL_SCALE: begin
        if (done_lo) begin
          low_d  = low_q + q_lo;
          high_d = low_q + q_hi;
          iter_d = '0;
        end
      end
      CTL_RESCALE: begin
        if (step_ok) begin
          if (held_q && (emit || stop)) begin
            out_valid_d = 1'b1;
            out_bit_d   = held_bit_q;
            out_cnt_d   = FollowW'(held_cnt_q);
            out_last_d  = stop;
            held_d      = 1'b0;
          end
          if (emit) begin
            held_d     = 1'b1;
            held_bit_d = !cond_lo;
            held_cnt_d = pend_q;
            pend_d     = '0;
          end else if (mid && pend_q != '1) begin
            pend_d = pend_q + PendW'(1);
          end
          if (!stop) begin
            low_d  = {low_sub[PRECISION-1:0], 1'b0};
            high_d = {high_sub[PRECISION-1:0], 1'b0};
            iter_d = iter_q + IterW'(1);
          end
        end
      end
      CTL_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_bit_d   = (low_q > Quarter);
          out_cnt_d   = FollowW'(pend_q) + FollowW'(1);
          out_last_d  = 1'b1;
          low_d       = '0;
          high_d      = Whole;
          pend_d      = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTL_IDLE;
      low_q       <= '0;
      high_q      <= Whole;
      pend_q      <= '0;
      iter_q      <= '0;
      held_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      low_q       <= low_d;
      high_q      <= high_d;
      pend_q      <= pend_d;
      iter_q      <= iter_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_bit_q <= held_bit_d;
    held_cnt_q <= held_cnt_d;
    out_bit_q  <= out_bit_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.lead_bit     = out_bit_q;
  assign res_o.follow_count = out_cnt_q;
  assign res_o.last         = out_last_q;

`ifndef NO_ASSERTIONS
  a_scalers_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_lo == done_hi)
    else $error("interval scalers finished on different cycles");

  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CTL_RESCALE) |-> (low_q <= high_q))
    else $error("lower bound above upper bound during rescale");

  a_high_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    high_q <= Whole)
    else $error("upper bound beyond full range");

  a_held_in_rescale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> (state_q == CTL_RESCALE))
    else $error("held result outside rescale");

  a_iter_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CTL_RESCALE) |-> (iter_q <= IterW'(IterCap)))
    else $error("rescale iteration count past cap");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_arith_encode_interval_core.sv =====
// Testbench for arith_encode_interval_core: random and directed requests vs a predictor.
`timescale 1ns / 100ps

module tb_arith_encode_interval_core;
  import aei_pkg::*;

  localparam int Prec      = PRECISION_DEF;
  localparam int FBits     = FREQ_BITS_DEF;
  localparam int PhaseReqs = 100;
  localparam int HoldLen   = 400;
  localparam int DrainWait = 200;

  localparam logic [63:0] Whole    = 64'd1 << Prec;
  localparam logic [63:0] Half     = 64'd1 << (Prec - 1);
  localparam logic [63:0] Quarter  = 64'd1 << (Prec - 2);
  localparam logic [63:0] ThreeQ   = 3 * Quarter;
  localparam logic [63:0] FreqMask = (64'd1 << FBits) - 1;

  typedef struct packed {
    cmd_e              command;
    logic [FieldW-1:0] cum_freq;
    logic [FieldW-1:0] freq;
    logic [FieldW-1:0] total;
  } sym_req_t;

  typedef struct packed {
    logic               lead_bit;
    logic [FollowW-1:0] follow_count;
    logic               last;
  } code_bit_t;

  logic clk;
  logic rst_n;

  aei_sym_if sym_if ();
  aei_res_if res_if ();

  arith_encode_interval_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .sym_i  (sym_if),
    .res_o  (res_if)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  sym_req_t  sym_pend[$];
  code_bit_t bits_due[$];

  int   n_queued     = 0;
  int   n_taken      = 0;
  int   fails        = 0;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic sym_taken    = 1'b0;
  logic hold_arm     = 1'b0;
  logic rx_hold      = 1'b0;

  // coder state as the predictor sees it
  logic [Prec:0]    cod_low;
  logic [Prec:0]    cod_high;
  logic [PendW-1:0] cod_pend;

  function automatic logic [63:0] share_of(input logic [63:0] w, input logic [63:0] c,
                                           input logic [63:0] t);
    logic [63:0] q;
    logic [63:0] r;
    q = w / t;
    r = w % t;
    return q * c + (64'd2 * r * c + t) / (64'd2 * t);
  endfunction

  task automatic clear_coder();
    cod_low  = '0;
    cod_high = Whole[Prec:0];
    cod_pend = '0;
  endtask

  task automatic push_bit(input logic b, input logic [FollowW-1:0] follow, input logic lst);
    code_bit_t cb;
    cb.lead_bit     = b;
    cb.follow_count = follow;
    cb.last         = lst;
    bits_due.push_back(cb);
  endtask

  task automatic narrow_and_rescale(input sym_req_t req);
    logic [63:0] cum;
    logic [63:0] fr;
    logic [63:0] tot;
    logic [63:0] top_c;
    logic [63:0] bot_c;
    logic [63:0] w;
    logic [63:0] lo;
    logic [63:0] hi;
    int          first;
    logic        stop;
    if (req.command == CMD_FINISH) begin
      push_bit((64'(cod_low) <= Quarter) ? 1'b0 : 1'b1, FollowW'(cod_pend) + 1'b1, 1'b1);
      clear_coder();
      return;
    end
    cum = 64'(req.cum_freq) & FreqMask;
    fr  = 64'(req.freq) & FreqMask;
    tot = 64'(req.total) & FreqMask;
    if (tot == 0) tot = 1;
    top_c = (cum + fr > tot) ? tot : cum + fr;
    bot_c = (cum > tot) ? tot : cum;
    lo    = 64'(cod_low);
    w     = 64'(cod_high) - lo;
    hi    = lo + share_of(w, top_c, tot);
    lo    = lo + share_of(w, bot_c, tot);
    first = bits_due.size();
    stop  = 1'b0;
    for (int it = 0; it < IterCap && !stop; it++) begin
      if (hi < Half) begin
        push_bit(1'b0, FollowW'(cod_pend), 1'b0);
        cod_pend = '0;
      end else if (lo > Half) begin
        push_bit(1'b1, FollowW'(cod_pend), 1'b0);
        cod_pend = '0;
        lo = lo - Half;
        hi = hi - Half;
      end else if (lo > Quarter && hi < ThreeQ) begin
        if (cod_pend != '1) cod_pend = cod_pend + 1'b1;
        lo = lo - Quarter;
        hi = hi - Quarter;
      end else begin
        stop = 1'b1;
      end
      if (!stop) begin
        lo = lo << 1;
        hi = hi << 1;
      end
    end
    cod_low  = lo[Prec:0];
    cod_high = hi[Prec:0];
    if (bits_due.size() > first) bits_due[bits_due.size() - 1].last = 1'b1;
  endtask

  // monitor: predicts on each accepted request, checks each accepted result
  always @(posedge clk) begin : monitor
    sym_req_t  req;
    code_bit_t want;
    if (!rst_n) begin
      clear_coder();
      sym_taken <= 1'b0;
    end else begin
      sym_taken <= sym_if.valid && sym_if.ready;
      if (sym_if.valid && sym_if.ready) begin
        req.command  = cmd_e'(sym_if.command);
        req.cum_freq = sym_if.cum_freq;
        req.freq     = sym_if.freq;
        req.total    = sym_if.total;
        narrow_and_rescale(req);
        n_taken++;
      end
      if (res_if.valid && res_if.ready) begin
        if (bits_due.size() == 0) begin
          $error("result with nothing expected: lead_bit %0d follow_count %0d last %0d",
                 res_if.lead_bit, res_if.follow_count, res_if.last);
          fails++;
        end else begin
          want = bits_due.pop_front();
          if (res_if.lead_bit !== want.lead_bit) begin
            $error("lead_bit: expected %0d, got %0d", want.lead_bit, res_if.lead_bit);
            fails++;
          end
          if (res_if.follow_count !== want.follow_count) begin
            $error("follow_count: expected %0d, got %0d", want.follow_count,
                   res_if.follow_count);
            fails++;
          end
          if (res_if.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, res_if.last);
            fails++;
          end
        end
      end
    end
  end

  // request driver
  always @(negedge clk) begin : sym_drive
    sym_req_t req;
    if (rst_n && (!sym_if.valid || sym_taken)) begin
      if (sym_pend.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        req = sym_pend.pop_front();
        sym_if.valid    <= 1'b1;
        sym_if.command  <= req.command;
        sym_if.cum_freq <= req.cum_freq;
        sym_if.freq     <= req.freq;
        sym_if.total    <= req.total;
      end else begin
        sym_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) res_if.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // long receiver hold-off so the output register fills and requests back up
  initial begin
    wait (hold_arm);
    rx_hold = 1'b1;
    repeat (HoldLen) @(posedge clk);
    rx_hold = 1'b0;
  end

  task automatic queue_req(input cmd_e cmd, input int cum, input int fr, input int tot);
    sym_req_t req;
    req.command  = cmd;
    req.cum_freq = FieldW'(cum);
    req.freq     = FieldW'(fr);
    req.total    = FieldW'(tot);
    sym_pend.push_back(req);
    n_queued++;
  endtask

  // mostly well-formed streams under a fixed model total, ended by a finish
  task automatic queue_phase(input int n_reqs);
    int made;
    int len;
    int tot;
    int fr;
    made = 0;
    while (made < n_reqs) begin
      if ($urandom_range(99) < 15) begin
        queue_req(($urandom_range(3) == 0) ? CMD_FINISH : CMD_ENCODE,
                  $urandom_range(0, 65535), $urandom_range(1, 65535),
                  $urandom_range(1, 65535));
        made++;
      end else begin
        len = $urandom_range(1, 30);
        tot = ($urandom_range(3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 400);
        repeat (len) begin
          fr = ($urandom_range(1) == 0) ? $urandom_range(1, tot / 16 + 1)
                                        : $urandom_range(1, tot);
          if (fr > tot) fr = tot;
          queue_req(CMD_ENCODE, $urandom_range(0, tot - fr), fr, tot);
        end
        queue_req(CMD_FINISH, $urandom_range(0, 65535), $urandom_range(1, 65535),
                  $urandom_range(1, 65535));
        made += len + 1;
      end
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input logic hold);
    tx_idle_pct  = idle;
    rx_stall_pct = stall;
    if (hold) hold_arm = 1'b1;
    queue_phase(PhaseReqs);
    while (sym_pend.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n           = 1'b0;
    sym_if.valid    = 1'b0;
    sym_if.command  = CMD_ENCODE;
    sym_if.cum_freq = '0;
    sym_if.freq     = '0;
    sym_if.total    = '0;
    res_if.ready    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    queue_req(CMD_FINISH, 0, 1, 1);
    queue_req(CMD_ENCODE, 0, 65535, 65535);  // whole interval, nothing emitted
    queue_req(CMD_ENCODE, 0, 1, 0);          // zero total
    queue_req(CMD_ENCODE, 0, 1, 65535);      // tiny low slice, run of zeros
    queue_req(CMD_ENCODE, 65535, 65535, 65535);
    queue_req(CMD_FINISH, 65535, 65535, 65535);
    queue_req(CMD_ENCODE, 65535, 65535, 100); // empty at the top: iteration cap
    queue_req(CMD_FINISH, 0, 1, 1);
    // upper bound at half, then empty there: pending climbs to saturation
    queue_req(CMD_ENCODE, 0, 1, 2);
    repeat (8) queue_req(CMD_ENCODE, 65535, 65535, 7);
    queue_req(CMD_FINISH, 0, 1, 1);
    queue_req(CMD_ENCODE, 32767, 1, 65535);
    queue_req(CMD_ENCODE, 16384, 32767, 65535);
    queue_req(CMD_FINISH, 0, 1, 1);
    while (sym_pend.size() != 0) @(posedge clk);

    run_phase(0, 0, 1'b1);
    run_phase(67, 0, 1'b0);
    run_phase(0, 67, 1'b0);
    run_phase(23, 23, 1'b0);

    while (n_taken != n_queued || bits_due.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/aei_pkg.sv
design/aei_sym_if.sv
design/aei_res_if.sv
design/aei_scale.sv
design/arith_encode_interval_core.sv
sim/tb_arith_encode_interval_core.sv
